/* rtl/acc_pkg.sv */
package acc_pkg;

    // Edit modes of the front-panel state machine
    typedef enum logic [2:0] {
        MODE_CLOCK         = 3'd0,
        MODE_TIME_HOURS    = 3'd1,
        MODE_TIME_MINUTES  = 3'd2,
        MODE_ALARM_HOURS   = 3'd3,
        MODE_ALARM_MINUTES = 3'd4
    } mode_t;

    // Command codes of an input transfer
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PRESS = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    // Button codes
    localparam logic [2:0] BTN_SET_TIME     = 3'd0;
    localparam logic [2:0] BTN_SET_ALARM    = 3'd1;
    localparam logic [2:0] BTN_SWITCH_ALARM = 3'd2;
    localparam logic [2:0] BTN_INC          = 3'd3;
    localparam logic [2:0] BTN_DEC          = 3'd4;

    // Light command codes
    localparam logic [1:0] LIGHT_NONE = 2'd0;
    localparam logic [1:0] LIGHT_ON   = 2'd1;
    localparam logic [1:0] LIGHT_OFF  = 2'd2;

    // Time of day limits
    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [5:0] MINUTE_MAX    = 6'd59;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] SECOND_MAX    = 6'd59;

    // The alarm only ever moves in whole minutes from its reset of 5 s,
    // so its seconds stay fixed; ringing starts 1 to 4 s after it
    localparam logic [5:0] ALARM_SECS  = 6'd5;
    localparam logic [5:0] RING_FIRST  = 6'd6;
    localparam logic [5:0] RING_LAST   = 6'd9;
    localparam logic [4:0] ALARM_RST_H = 5'd0;
    localparam logic [5:0] ALARM_RST_M = 6'd0;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
    } hm_t;

    function automatic logic [4:0] hour_inc(input logic [4:0] h);
        hour_inc = (h == HOUR_MAX) ? 5'd0 : h + 5'd1;
    endfunction

    function automatic logic [4:0] hour_dec(input logic [4:0] h);
        hour_dec = (h == 5'd0) ? HOUR_MAX : h - 5'd1;
    endfunction

    function automatic hm_t hm_inc(input hm_t t);
        hm_t r;
        r = t;
        if (t.minutes == MINUTE_MAX) begin
            r.minutes = 6'd0;
            r.hours   = hour_inc(t.hours);
        end else begin
            r.minutes = t.minutes + 6'd1;
        end
        return r;
    endfunction

    function automatic hm_t hm_dec(input hm_t t);
        hm_t r;
        r = t;
        if (t.minutes == 6'd0) begin
            r.minutes = MINUTE_MAX;
            r.hours   = hour_dec(t.hours);
        end else begin
            r.minutes = t.minutes - 6'd1;
        end
        return r;
    endfunction

endpackage

/* rtl/alarm_clock_controller_top.sv */
// Alarm clock controller: keeps the time of day as hours, minutes and seconds
// counters, an alarm time in whole minutes, a five-way edit mode, the alarm
// enable, the ringing latch and the light state. Each input transfer is a
// one-second tick, a button press or a load of hours and minutes; each gives
// exactly one result transfer with the full state after it. One item is taken
// every clock cycle while s_ready is high; its result appears next cycle from
// the single register level of counter and compare logic behind the input
// port. s_ready stays high while the result register is empty or being taken.
module alarm_clock_controller_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [2:0] s_button,
    input  logic [4:0] s_load_hours,
    input  logic [5:0] s_load_minutes,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_time_hours,
    output logic [5:0] m_time_minutes,
    output logic [5:0] m_time_secs,
    output logic [4:0] m_alarm_hours,
    output logic [5:0] m_alarm_minutes,
    output logic       m_alarm_enabled,
    output logic       m_ringing,
    output logic [1:0] m_light_cmd,
    output logic [2:0] m_edit_mode
);

    acc_pkg::hm_t    time_hm_reg, time_hm_next;
    logic [5:0]      time_secs_reg, time_secs_next;
    acc_pkg::hm_t    alarm_hm_reg, alarm_hm_next;
    acc_pkg::mode_t  mode_reg, mode_next;
    logic            armed_reg, armed_next;
    logic            ring_reg, ring_next;
    logic            light_reg, light_next;
    logic [1:0]      light_cmd_reg, light_cmd_next;
    logic            m_valid_reg, m_valid_next;
    logic            s_fire;
    logic [5:0]      load_min;
    logic [5:0]      load_hour;
    logic            in_window;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Fold an oversized load back into one day
    always_comb begin
        if (s_load_minutes > acc_pkg::MINUTE_MAX) begin
            load_min  = s_load_minutes - acc_pkg::MINS_PER_HOUR;
            load_hour = {1'b0, s_load_hours} + 6'd1;
        end else begin
            load_min  = s_load_minutes;
            load_hour = {1'b0, s_load_hours};
        end
        if (load_hour >= acc_pkg::HOURS_PER_DAY) begin
            load_hour = load_hour - acc_pkg::HOURS_PER_DAY;
        end
    end

    // Update the state for the accepted item
    always_comb begin
        time_hm_next   = time_hm_reg;
        time_secs_next = time_secs_reg;
        alarm_hm_next  = alarm_hm_reg;
        mode_next      = mode_reg;
        armed_next     = armed_reg;
        ring_next      = ring_reg;
        light_next     = light_reg;
        light_cmd_next = light_cmd_reg;
        in_window      = 1'b0;

        if (s_fire) begin
            unique case (s_cmd)
                acc_pkg::CMD_TICK: begin
                    if (time_secs_reg == acc_pkg::SECOND_MAX) begin
                        time_secs_next = 6'd0;
                        time_hm_next   = acc_pkg::hm_inc(time_hm_reg);
                    end else begin
                        time_secs_next = time_secs_reg + 6'd1;
                    end
                end
                acc_pkg::CMD_PRESS: begin
                    unique case (mode_reg)
                        acc_pkg::MODE_TIME_HOURS: begin
                            if (s_button == acc_pkg::BTN_INC) begin
                                time_hm_next.hours = acc_pkg::hour_inc(time_hm_reg.hours);
                            end else if (s_button == acc_pkg::BTN_DEC) begin
                                time_hm_next.hours = acc_pkg::hour_dec(time_hm_reg.hours);
                            end else if (s_button == acc_pkg::BTN_SET_TIME) begin
                                mode_next = acc_pkg::MODE_TIME_MINUTES;
                            end
                        end
                        acc_pkg::MODE_TIME_MINUTES: begin
                            if (s_button == acc_pkg::BTN_INC) begin
                                time_secs_next = 6'd0;
                                time_hm_next   = acc_pkg::hm_inc(time_hm_reg);
                            end else if (s_button == acc_pkg::BTN_DEC) begin
                                time_secs_next = 6'd0;
                                time_hm_next   = acc_pkg::hm_dec(time_hm_reg);
                            end else if (s_button == acc_pkg::BTN_SET_TIME) begin
                                mode_next = acc_pkg::MODE_CLOCK;
                            end
                        end
                        acc_pkg::MODE_ALARM_HOURS: begin
                            if (s_button == acc_pkg::BTN_INC) begin
                                alarm_hm_next.hours = acc_pkg::hour_inc(alarm_hm_reg.hours);
                            end else if (s_button == acc_pkg::BTN_DEC) begin
                                alarm_hm_next.hours = acc_pkg::hour_dec(alarm_hm_reg.hours);
                            end else if (s_button == acc_pkg::BTN_SET_ALARM) begin
                                mode_next = acc_pkg::MODE_ALARM_MINUTES;
                            end
                        end
                        acc_pkg::MODE_ALARM_MINUTES: begin
                            if (s_button == acc_pkg::BTN_INC) begin
                                alarm_hm_next = acc_pkg::hm_inc(alarm_hm_reg);
                            end else if (s_button == acc_pkg::BTN_DEC) begin
                                alarm_hm_next = acc_pkg::hm_dec(alarm_hm_reg);
                            end else if (s_button == acc_pkg::BTN_SET_ALARM) begin
                                armed_next = 1'b1;
                                mode_next  = acc_pkg::MODE_CLOCK;
                            end
                        end
                        default: begin
                            mode_next = acc_pkg::MODE_CLOCK;
                            if (s_button == acc_pkg::BTN_SET_TIME) begin
                                mode_next = acc_pkg::MODE_TIME_HOURS;
                            end else if (s_button == acc_pkg::BTN_SET_ALARM) begin
                                mode_next = acc_pkg::MODE_ALARM_HOURS;
                            end else if (s_button == acc_pkg::BTN_SWITCH_ALARM) begin
                                armed_next = !armed_reg;
                                ring_next  = 1'b0;
                            end
                        end
                    endcase
                end
                acc_pkg::CMD_LOAD: begin
                    time_hm_next.hours   = load_hour[4:0];
                    time_hm_next.minutes = load_min;
                    time_secs_next       = 6'd0;
                end
                default: begin
                end
            endcase

            // Latch ringing in the four seconds after the alarm time
            in_window = (time_hm_next == alarm_hm_next)
                     && (time_secs_next >= acc_pkg::RING_FIRST)
                     && (time_secs_next <= acc_pkg::RING_LAST);
            if (!ring_next && armed_next && in_window) begin
                ring_next = 1'b1;
            end

            // Drive the light to follow the latch
            light_cmd_next = acc_pkg::LIGHT_NONE;
            if (ring_next && !light_reg) begin
                light_next     = 1'b1;
                light_cmd_next = acc_pkg::LIGHT_ON;
            end else if (!ring_next && light_reg) begin
                light_next     = 1'b0;
                light_cmd_next = acc_pkg::LIGHT_OFF;
            end
        end
    end

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    // Hold the state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_hm_reg   <= '0;
            time_secs_reg <= '0;
            alarm_hm_reg  <= '{hours: acc_pkg::ALARM_RST_H, minutes: acc_pkg::ALARM_RST_M};
            mode_reg      <= acc_pkg::MODE_CLOCK;
            armed_reg     <= 1'b0;
            ring_reg      <= 1'b0;
            light_reg     <= 1'b0;
            light_cmd_reg <= acc_pkg::LIGHT_NONE;
            m_valid_reg   <= 1'b0;
        end else begin
            time_hm_reg   <= time_hm_next;
            time_secs_reg <= time_secs_next;
            alarm_hm_reg  <= alarm_hm_next;
            mode_reg      <= mode_next;
            armed_reg     <= armed_next;
            ring_reg      <= ring_next;
            light_reg     <= light_next;
            light_cmd_reg <= light_cmd_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_time_hours    = time_hm_reg.hours;
    assign m_time_minutes  = time_hm_reg.minutes;
    assign m_time_secs     = time_secs_reg;
    assign m_alarm_hours   = alarm_hm_reg.hours;
    assign m_alarm_minutes = alarm_hm_reg.minutes;
    assign m_alarm_enabled = armed_reg;
    assign m_ringing       = ring_reg;
    assign m_light_cmd     = light_cmd_reg;
    assign m_edit_mode     = mode_reg;

    // A light-on command only ever goes out with the latch set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_light_cmd == acc_pkg::LIGHT_ON) |-> m_ringing)
        else $error("light on sent without ringing");

    // The light state always agrees with the latch in a delivered result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (light_reg == ring_reg))
        else $error("light state out of step with ring latch");

    // Time fields stay within one day
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_time_hours <= acc_pkg::HOUR_MAX)
                 && (m_time_minutes <= acc_pkg::MINUTE_MAX)
                 && (m_time_secs <= acc_pkg::SECOND_MAX))
        else $error("time of day out of range");

    // A stalled result blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted over a stalled result");

endmodule
